>>> rtl/core/frd_pkg.sv
// Shared constants and types for the Fresnel reflectance pipeline.
package frd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SQ_W      = 50;
    localparam int SQ_CELLS  = SQ_W / 2;
    localparam int DIV_W     = 44;
    localparam int QUO_W     = 24;
    localparam int ETA_CELLS = 24;
    localparam int AB_CELLS  = 16;
    localparam int LATENCY   = 100;

    // Item tag carried alongside the arithmetic through every cell.
    typedef struct packed {
        logic        vld;
        logic        cmd;
        logic        force_one;
        logic        sat_e;
        logic        sat_a;
        logic        sat_b;
        logic [16:0] cq;
        logic [19:0] eq0;
    } t_tag;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] res;
        logic [SQ_W-1:0] mask;
    } t_sqrt;

    typedef struct packed {
        logic [DIV_W-1:0] n;
        logic [DIV_W-1:0] d;
        logic [QUO_W-1:0] q;
    } t_div;

    // A tag with its valid flag cleared, as loaded while in reset.
    function automatic t_tag tag_cleared(input t_tag tag);
        t_tag cleared;
        cleared     = tag;
        cleared.vld = 1'b0;
        return cleared;
    endfunction

endpackage

>>> rtl/core/frd_sqrt_cell.sv
// One step of a digit-by-digit integer square root, registered.
module frd_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  frd_pkg::t_tag  i_tag,
    input  frd_pkg::t_sqrt i_data,
    output frd_pkg::t_tag  o_tag,
    output frd_pkg::t_sqrt o_data
);
    import frd_pkg::*;

    t_tag            r_tag;
    t_sqrt           r_data;
    t_sqrt           n_data;
    logic [SQ_W-1:0] trial;

    always_comb begin
        trial       = i_data.res + i_data.mask;
        n_data.mask = i_data.mask >> 2;
        if (i_data.v >= trial) begin
            n_data.v   = i_data.v - trial;
            n_data.res = (i_data.res >> 1) + i_data.mask;
        end else begin
            n_data.v   = i_data.v;
            n_data.res = i_data.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_tag <= tag_cleared(i_tag);
        end else begin
            r_tag <= i_tag;
        end
    end

    assign o_tag  = r_tag;
    assign o_data = r_data;

endmodule

>>> rtl/core/frd_div_cell.sv
// One quotient bit of a restoring divider, registered.
module frd_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  frd_pkg::t_tag i_tag,
    input  frd_pkg::t_div i_data,
    output frd_pkg::t_tag o_tag,
    output frd_pkg::t_div o_data
);
    import frd_pkg::*;

    t_tag r_tag;
    t_div r_data;
    t_div n_data;

    always_comb begin
        n_data.d = i_data.d >> 1;
        if (i_data.n >= i_data.d) begin
            n_data.n = i_data.n - i_data.d;
            n_data.q = {i_data.q[QUO_W-2:0], 1'b1};
        end else begin
            n_data.n = i_data.n;
            n_data.q = {i_data.q[QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_tag <= tag_cleared(i_tag);
        end else begin
            r_tag <= i_tag;
        end
    end

    assign o_tag  = r_tag;
    assign o_data = r_data;

endmodule

>>> rtl/core/fresnel_dielectric_reflectance_top.sv
// Top level of the unpolarised dielectric Fresnel reflectance pipeline.
//
// An item is transferred in at a rising edge where start is high and busy is
// low. The cosine, the relative index, the normal-incidence reflectance and
// the command travel on ports of their own. Busy is held low permanently:
// the whole block is a row of registered cells, so a new item may be
// transferred on every clock cycle and each is followed by exactly one result.
// A result is held on o_reflectance_out and o_total_reflection for a single
// cycle, marked by o_valid. Between the edge that took the item in and the
// edge that transfers its result out lie the chains of cells: two square-root
// chains of 25 cells, the index divider of 24 cells and the twin ratio
// dividers of 16 cells, plus the ten entry, multiply, select and output
// stages between them.
// The receiver cannot hold results off, and none is needed: results leave in
// the order items arrived, one per cycle at most.
// A synchronous reset clears the valid flag of every stage, so any items in
// flight are discarded; the payload registers are not reset.
module fresnel_dielectric_reflectance_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [15:0] i_cos_incident,
    input  logic [15:0] i_relative_ior,
    input  logic [16:0] i_normal_reflectance,
    output logic        o_valid,
    output logic [16:0] o_reflectance_out,
    output logic        o_total_reflection
);
    import frd_pkg::*;

    // Entry stage: the cosine is clamped to one and every input is
    // brought to sixteen fraction bits.
    t_tag        r_s0_tag;
    t_tag        n_s0_tag;
    logic [15:0] r_s0_nr;
    logic [15:0] cin_sat;

    always_comb begin
        cin_sat = (i_cos_incident > 16'd32768) ? 16'd32768 : i_cos_incident;
        n_s0_tag.vld       = start & ~busy;
        n_s0_tag.cmd       = i_cmd;
        n_s0_tag.force_one = i_cmd & i_normal_reflectance[16];
        n_s0_tag.sat_e     = 1'b0;
        n_s0_tag.sat_a     = 1'b0;
        n_s0_tag.sat_b     = 1'b0;
        n_s0_tag.cq        = {cin_sat, 1'b0};
        n_s0_tag.eq0       = {i_relative_ior, 4'b0};
    end

    always_ff @(posedge i_clk) begin
        r_s0_nr <= i_normal_reflectance[15:0];
        if (!i_rst_n) begin
            r_s0_tag <= tag_cleared(n_s0_tag);
        end else begin
            r_s0_tag <= n_s0_tag;
        end
    end

    // First square-root chain: the square root of the normal reflectance.
    t_tag  sq1_tag [0:SQ_CELLS];
    t_sqrt sq1_dat [0:SQ_CELLS];

    assign sq1_tag[0]      = r_s0_tag;
    assign sq1_dat[0].v    = {18'b0, r_s0_nr, 16'b0};
    assign sq1_dat[0].res  = '0;
    assign sq1_dat[0].mask = SQ_W'(1) << (SQ_W - 2);

    for (genvar gi = 0; gi < SQ_CELLS; gi++) begin : g_sq1
        frd_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (sq1_tag[gi]),
            .i_data  (sq1_dat[gi]),
            .o_tag   (sq1_tag[gi+1]),
            .o_data  (sq1_dat[gi+1])
        );
    end

    // Index setup: (1 + sqrt r) / (1 - sqrt r), with the saturation of the
    // quotient decided here so that the divider needs only 24 bits.
    t_tag        r_e_tag;
    t_tag        n_e_tag;
    logic [33:0] r_e_num;
    logic [33:0] n_e_num;
    logic [16:0] r_e_den;
    logic [16:0] n_e_den;
    logic [15:0] rt;

    always_comb begin
        rt = (sq1_dat[SQ_CELLS].res >= SQ_W'(65536)) ? 16'hFFFF
                                                     : sq1_dat[SQ_CELLS].res[15:0];
        n_e_num = {1'b0, 17'h10000 + {1'b0, rt}, 16'b0};
        n_e_den = 17'h10000 - {1'b0, rt};
        n_e_tag = sq1_tag[SQ_CELLS];
        n_e_tag.sat_e = ({7'b0, n_e_num} >= {n_e_den, 24'b0});
    end

    always_ff @(posedge i_clk) begin
        r_e_num <= n_e_num;
        r_e_den <= n_e_den;
        if (!i_rst_n) begin
            r_e_tag <= tag_cleared(n_e_tag);
        end else begin
            r_e_tag <= n_e_tag;
        end
    end

    // Index divider chain.
    t_tag eta_tag [0:ETA_CELLS];
    t_div eta_dat [0:ETA_CELLS];

    assign eta_tag[0]   = r_e_tag;
    assign eta_dat[0].n = {10'b0, r_e_num};
    assign eta_dat[0].d = {4'b0, r_e_den, 23'b0};
    assign eta_dat[0].q = '0;

    for (genvar gi = 0; gi < ETA_CELLS; gi++) begin : g_eta
        frd_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (eta_tag[gi]),
            .i_data  (eta_dat[gi]),
            .o_tag   (eta_tag[gi+1]),
            .o_data  (eta_dat[gi+1])
        );
    end

    // Index selection.
    t_tag        r_f_tag;
    logic [23:0] r_f_eq;
    logic [23:0] n_f_eq;

    always_comb begin
        if (eta_tag[ETA_CELLS].cmd) begin
            n_f_eq = eta_tag[ETA_CELLS].sat_e ? 24'hFFFFFF : eta_dat[ETA_CELLS].q;
        end else begin
            n_f_eq = {4'b0, eta_tag[ETA_CELLS].eq0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_eq <= n_f_eq;
        if (!i_rst_n) begin
            r_f_tag <= tag_cleared(eta_tag[ETA_CELLS]);
        end else begin
            r_f_tag <= eta_tag[ETA_CELLS];
        end
    end

    // Squares of the index and of the cosine.
    t_tag        r_m_tag;
    logic [47:0] r_m_e2;
    logic [33:0] r_m_c2;

    always_ff @(posedge i_clk) begin
        r_m_e2 <= r_f_eq * r_f_eq;
        r_m_c2 <= r_f_tag.cq * r_f_tag.cq;
        if (!i_rst_n) begin
            r_m_tag <= tag_cleared(r_f_tag);
        end else begin
            r_m_tag <= r_f_tag;
        end
    end

    // g = eta^2 - 1 + cos^2, clamped at zero; zero means total reflection.
    t_tag        r_t_tag;
    t_tag        n_t_tag;
    logic [48:0] r_t_tq;
    logic [48:0] n_t_tq;
    logic [48:0] e2_x;
    logic [48:0] c2_x;
    logic [48:0] gap;

    always_comb begin
        e2_x = {1'b0, r_m_e2};
        c2_x = {15'b0, r_m_c2};
        gap  = 49'h1_0000_0000 - e2_x;
        if (e2_x >= 49'h1_0000_0000) begin
            n_t_tq = (e2_x - 49'h1_0000_0000) + c2_x;
        end else begin
            n_t_tq = (c2_x > gap) ? c2_x - gap : '0;
        end
        n_t_tag = r_m_tag;
        n_t_tag.force_one = r_m_tag.force_one | (n_t_tq == '0);
    end

    always_ff @(posedge i_clk) begin
        r_t_tq <= n_t_tq;
        if (!i_rst_n) begin
            r_t_tag <= tag_cleared(n_t_tag);
        end else begin
            r_t_tag <= n_t_tag;
        end
    end

    // Second square-root chain: s = sqrt(g).
    t_tag  sq2_tag [0:SQ_CELLS];
    t_sqrt sq2_dat [0:SQ_CELLS];

    assign sq2_tag[0]      = r_t_tag;
    assign sq2_dat[0].v    = {1'b0, r_t_tq};
    assign sq2_dat[0].res  = '0;
    assign sq2_dat[0].mask = SQ_W'(1) << (SQ_W - 2);

    for (genvar gi = 0; gi < SQ_CELLS; gi++) begin : g_sq2
        frd_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (sq2_tag[gi]),
            .i_data  (sq2_dat[gi]),
            .o_tag   (sq2_tag[gi+1]),
            .o_data  (sq2_dat[gi+1])
        );
    end

    // Sum, difference and the two products that feed the B ratio.
    t_tag        r_p_tag;
    t_tag        n_p_tag;
    logic [25:0] r_p_sum;
    logic [25:0] n_p_sum;
    logic [25:0] r_p_diff;
    logic [25:0] n_p_diff;
    logic [42:0] r_p_pa;
    logic [42:0] r_p_pb;
    logic        r_p_ge;
    logic        n_p_ge;
    logic [25:0] sq_x;
    logic [25:0] cq_x;

    always_comb begin
        sq_x     = {1'b0, sq2_dat[SQ_CELLS].res[24:0]};
        cq_x     = {9'b0, sq2_tag[SQ_CELLS].cq};
        n_p_sum  = sq_x + cq_x;
        n_p_ge   = (sq_x >= cq_x);
        n_p_diff = n_p_ge ? sq_x - cq_x : cq_x - sq_x;
        n_p_tag  = sq2_tag[SQ_CELLS];
        n_p_tag.sat_a = (n_p_diff >= n_p_sum);
    end

    always_ff @(posedge i_clk) begin
        r_p_sum  <= n_p_sum;
        r_p_diff <= n_p_diff;
        r_p_ge   <= n_p_ge;
        r_p_pa   <= n_p_tag.cq * n_p_sum;
        r_p_pb   <= n_p_tag.cq * n_p_diff;
        if (!i_rst_n) begin
            r_p_tag <= tag_cleared(n_p_tag);
        end else begin
            r_p_tag <= n_p_tag;
        end
    end

    // Numerator and denominator of B, each floored to sixteen fraction bits.
    t_tag        r_q_tag;
    t_tag        n_q_tag;
    logic [27:0] r_q_numq;
    logic [27:0] n_q_numq;
    logic [27:0] r_q_denq;
    logic [27:0] n_q_denq;
    logic [25:0] r_q_sum;
    logic [25:0] r_q_diff;
    logic [43:0] pa_x;
    logic [43:0] num_mag;
    logic [43:0] den2;

    always_comb begin
        pa_x     = {1'b0, r_p_pa};
        num_mag  = (pa_x >= 44'h1_0000_0000) ? pa_x - 44'h1_0000_0000
                                             : 44'h1_0000_0000 - pa_x;
        n_q_numq = num_mag[43:16];
        den2     = r_p_ge ? 44'h1_0000_0000 + {1'b0, r_p_pb}
                          : 44'h1_0000_0000 - {1'b0, r_p_pb};
        n_q_denq = (den2[43:16] == '0) ? 28'd1 : den2[43:16];
        n_q_tag  = r_p_tag;
        n_q_tag.sat_b = (n_q_numq >= n_q_denq);
    end

    always_ff @(posedge i_clk) begin
        r_q_numq <= n_q_numq;
        r_q_denq <= n_q_denq;
        r_q_sum  <= r_p_sum;
        r_q_diff <= r_p_diff;
        if (!i_rst_n) begin
            r_q_tag <= tag_cleared(n_q_tag);
        end else begin
            r_q_tag <= n_q_tag;
        end
    end

    // Twin divider chains for the ratios A and B.
    t_tag da_tag [0:AB_CELLS];
    t_div da_dat [0:AB_CELLS];
    t_tag db_tag [0:AB_CELLS];
    t_div db_dat [0:AB_CELLS];

    assign da_tag[0]   = r_q_tag;
    assign da_dat[0].n = {2'b0, r_q_diff, 16'b0};
    assign da_dat[0].d = {3'b0, r_q_sum, 15'b0};
    assign da_dat[0].q = '0;
    assign db_tag[0]   = r_q_tag;
    assign db_dat[0].n = {r_q_numq, 16'b0};
    assign db_dat[0].d = {1'b0, r_q_denq, 15'b0};
    assign db_dat[0].q = '0;

    for (genvar gi = 0; gi < AB_CELLS; gi++) begin : g_ab
        frd_div_cell u_cell_a (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (da_tag[gi]),
            .i_data  (da_dat[gi]),
            .o_tag   (da_tag[gi+1]),
            .o_data  (da_dat[gi+1])
        );
        frd_div_cell u_cell_b (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (db_tag[gi]),
            .i_data  (db_dat[gi]),
            .o_tag   (db_tag[gi+1]),
            .o_data  (db_dat[gi+1])
        );
    end

    // Squares of the ratios, saturated at one.
    t_tag        r_s_tag;
    logic [16:0] r_s_a2;
    logic [16:0] r_s_b2;
    logic [16:0] aq;
    logic [16:0] bq;
    logic [33:0] a_sq;
    logic [33:0] b_sq;

    always_comb begin
        aq   = da_tag[AB_CELLS].sat_a ? 17'h10000 : {1'b0, da_dat[AB_CELLS].q[15:0]};
        bq   = db_tag[AB_CELLS].sat_b ? 17'h10000 : {1'b0, db_dat[AB_CELLS].q[15:0]};
        a_sq = aq * aq;
        b_sq = bq * bq;
    end

    always_ff @(posedge i_clk) begin
        r_s_a2 <= a_sq[32:16];
        r_s_b2 <= b_sq[32:16];
        if (!i_rst_n) begin
            r_s_tag <= tag_cleared(db_tag[AB_CELLS]);
        end else begin
            r_s_tag <= db_tag[AB_CELLS];
        end
    end

    // A^2 * (1 + B^2).
    t_tag        r_r_tag;
    logic [34:0] r_r_prod;

    always_ff @(posedge i_clk) begin
        r_r_prod <= r_s_a2 * ({1'b0, r_s_b2} + 18'h10000);
        if (!i_rst_n) begin
            r_r_tag <= tag_cleared(r_s_tag);
        end else begin
            r_r_tag <= r_s_tag;
        end
    end

    // Halve to Q1.16, truncating, and clamp at one.
    logic [17:0] resq;
    logic [33:0] rnd;
    logic [17:0] r16;
    logic        r_valid;
    logic [16:0] r_refl;
    logic        r_flag;

    always_comb begin
        resq = r_r_prod[34:17];
        rnd  = ({resq, 16'b0} + 34'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        r16  = rnd[17:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_r_tag.force_one || r16 >= 18'h10000) begin
            r_refl <= 17'h10000;
            r_flag <= 1'b1;
        end else begin
            r_refl <= r16[16:0];
            r_flag <= 1'b0;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_r_tag.vld;
        end
    end

    assign busy               = 1'b0;
    assign o_valid            = r_valid;
    assign o_reflectance_out  = r_refl;
    assign o_total_reflection = r_flag;

    // The flag and a full-scale result always go together.
    a_flag_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_total_reflection |-> o_reflectance_out == 17'h10000)
        else $error("total reflection flag without full-scale result");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_total_reflection |-> o_reflectance_out < 17'h10000)
        else $error("full-scale result without total reflection flag");

    // Every result stems from an item transferred a fixed time earlier.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without a matching input transfer");

endmodule
